FILE: rtl/disjoint_set_union_find_assert.svh
// ----------------------------------------------------------------------------
// disjoint_set_union_find_assert
// assertion macros used by the checker file dsu_checker
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_FIND_ASSERT_SVH
`define DISJOINT_SET_UNION_FIND_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define DSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dsu assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define DSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dsu assertion failed");

`endif

FILE: rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// types and constants of the disjoint-set engine
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int ELEM_W   = 10;
    localparam int RANK_W   = 4;
    localparam int CLAMP_W  = 17;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_RANK,
        ST_LINK,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/disjoint_set_union_find.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// union-find engine with path compression and union by rank
//
// input words arrive on s_ (operation in s_tuser, elements in s_tdata), one
// result word leaves on m_ for each input word. a find returns the root of
// the first element; a union finds both roots and links them by rank.
// after reset a clearing pass over all entries writes every parent
// entry to its own index and every rank to zero; s_tready stays low meanwhile.
// one request is worked at a time over the parent ram: a walk reads one link
// per cycle, then a compression pass rewrites one link per cycle.
// a find walks to the root, then compresses the path; a union does this for
// both elements, then reads both ranks in ST_RANK and ST_LINK and links the
// roots, skipping the rank reads and the link when both already share a root.
// the result sits in an output register, so the next word is accepted while
// it waits; if the receiver still stalls when the next result is ready,
// the engine holds that result until m_tready frees the register
// ----------------------------------------------------------------------------
module disjoint_set_union_find
    import dsu_pkg::*;
#(
    parameter int ELEMENT_COUNT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // first_element, second_element
    input  logic                s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // root_index, already_joined
);

    localparam int IDX_W = $clog2(ELEMENT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ELEMENT_COUNT - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              op_reg, op_next;
    logic              phase_reg, phase_next;
    logic [IDX_W-1:0]  second_reg, second_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [IDX_W-1:0]  root_a_reg, root_a_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [IDX_W-1:0]  surv_reg, surv_next;
    logic              joined_reg, joined_next;
    logic [ELEM_W-1:0] m_root_reg, m_root_next;
    logic              m_joined_reg, m_joined_next;

    logic              par_we;
    logic [IDX_W-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
    logic              rank_we;
    logic [IDX_W-1:0]  rank_waddr, rank_raddr;
    logic [RANK_W-1:0] rank_wdata, rank_rdata;

    logic [CLAMP_W-1:0] a_wide, b_wide, surv_wide;
    logic [IDX_W-1:0]   a_in, b_in;
    logic               out_free;

    dsu_ram #(.WIDTH(IDX_W), .DEPTH(ELEMENT_COUNT)) u_parent_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    dsu_ram #(.WIDTH(RANK_W), .DEPTH(ELEMENT_COUNT)) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    // out-of-range elements saturate to the last index
    assign a_wide = CLAMP_W'(s_tdata[ELEM_W-1:0]);
    assign b_wide = CLAMP_W'(s_tdata[2*ELEM_W-1:ELEM_W]);
    assign a_in   = (a_wide >= CLAMP_W'(ELEMENT_COUNT)) ? IDX_LAST : IDX_W'(a_wide);
    assign b_in   = (b_wide >= CLAMP_W'(ELEMENT_COUNT)) ? IDX_LAST : IDX_W'(b_wide);

    assign surv_wide = CLAMP_W'(surv_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - ELEM_W - 1){1'b0}}, m_joined_reg, m_root_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (par_rdata == cur_reg) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (cur_reg == root_reg) begin
                    if (!phase_reg) begin
                        state_next = (op_reg == OP_FIND) ? ST_FINISH : ST_WALK;
                    end else begin
                        state_next = (cur_reg == root_a_reg) ? ST_FINISH : ST_RANK;
                    end
                end
            end
            ST_RANK:   state_next = ST_LINK;
            ST_LINK:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        op_next       = op_reg;
        phase_next    = phase_reg;
        second_next   = second_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        root_a_next   = root_a_reg;
        rank_a_next   = rank_a_reg;
        surv_next     = surv_reg;
        joined_next   = joined_reg;
        m_root_next   = m_root_reg;
        m_joined_next = m_joined_reg;
        par_we        = 1'b0;
        par_waddr     = cur_reg;
        par_wdata     = root_reg;
        par_raddr     = cur_reg;
        rank_we       = 1'b0;
        rank_waddr    = root_a_reg;
        rank_wdata    = '0;
        rank_raddr    = root_a_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                par_we     = 1'b1;
                par_waddr  = clr_reg;
                par_wdata  = clr_reg;
                rank_we    = 1'b1;
                rank_waddr = clr_reg;
                clr_next   = IDX_W'(clr_reg + 1'b1);
            end
            ST_IDLE: begin
                par_raddr = a_in;
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    phase_next  = 1'b0;
                    node_next   = a_in;
                    cur_next    = a_in;
                    second_next = b_in;
                end
            end
            ST_WALK: begin
                if (par_rdata == cur_reg) begin
                    root_next = cur_reg;
                    cur_next  = node_reg;
                    par_raddr = node_reg;
                end else begin
                    cur_next  = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            ST_COMP: begin
                if (cur_reg != root_reg) begin
                    par_we    = 1'b1;
                    cur_next  = par_rdata;
                    par_raddr = par_rdata;
                end else if (!phase_reg) begin
                    root_a_next = root_reg;
                    surv_next   = root_reg;
                    joined_next = 1'b0;
                    phase_next  = 1'b1;
                    node_next   = second_reg;
                    cur_next    = second_reg;
                    par_raddr   = second_reg;
                end else begin
                    surv_next   = root_a_reg;
                    joined_next = (root_reg == root_a_reg);
                end
            end
            ST_RANK: begin
                rank_a_next = rank_rdata;
                rank_raddr  = root_reg;
            end
            ST_LINK: begin
                par_we = 1'b1;
                priority if (rank_a_reg < rank_rdata) begin
                    par_waddr = root_a_reg;
                    par_wdata = root_reg;
                    surv_next = root_reg;
                end else begin
                    par_waddr = root_reg;
                    par_wdata = root_a_reg;
                    surv_next = root_a_reg;
                    if (rank_a_reg == rank_rdata && rank_a_reg != RANK_MAX) begin
                        rank_we    = 1'b1;
                        rank_wdata = RANK_W'(rank_a_reg + 1'b1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_root_next   = ELEM_W'(surv_wide);
                    m_joined_next = joined_reg;
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        phase_reg    <= phase_next;
        second_reg   <= second_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        root_a_reg   <= root_a_next;
        rank_a_reg   <= rank_a_next;
        surv_reg     <= surv_next;
        joined_reg   <= joined_next;
        m_root_reg   <= m_root_next;
        m_joined_reg <= m_joined_next;
    end

endmodule

FILE: rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dsu_checker.sv
// ----------------------------------------------------------------------------
// dsu_checker
// port-level checks of the disjoint-set engine, bound to the top level
// ----------------------------------------------------------------------------
`include "disjoint_set_union_find_assert.svh"

module dsu_checker
    import dsu_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled result word holds
    `DSU_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time: busy right after an accepted word
    `DSU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a new result only appears after work, never out of idle
    `DSU_ASSERT_IMP(a_result_from_work, $rose(m_tvalid), !$past(s_tready))

    // padding bits of the result word stay zero
    `DSU_ASSERT_IMP(a_m_pad_zero, m_tvalid, m_tdata[M_DATA_W-1:ELEM_W+1] == '0)

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (.*);

FILE: sim/disjoint_set_union_find_tb.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_find_tb
// self-checking bench for the union-find engine
//
// a short table of find and union words runs first, some rows carrying the
// result expected straight after reset; the rest of the table and a long
// random stream are checked against a forest kept in the bench, with its
// own parent and rank tables and path compression. both sides idle in
// random bursts, and once the receiver holds off long enough for the
// engine to back up into its input.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_tb;
    import dsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEMENT_COUNT = 1024;
    localparam int RANDOM_WORDS  = 1100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int TABLE_ROWS    = 23;

    typedef struct packed {
        logic              joined;
        logic [ELEM_W-1:0] root;
    } result_t;

    typedef struct packed {
        logic              op;
        logic [ELEM_W-1:0] first;
        logic [ELEM_W-1:0] second;
        logic              known;
        logic [ELEM_W-1:0] root;
        logic              joined;
    } table_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    logic [ELEM_W-1:0] forest_parent [ELEMENT_COUNT];
    logic [RANK_W-1:0] forest_rank   [ELEMENT_COUNT];
    result_t           pending_results [$];

    int  mismatches = 0;
    int  stall_cycles = 0;
    bit  idle_on;
    bit  hold_asked;
    bit  hold_taken;

    table_row_t stim_table [TABLE_ROWS] = '{
        '{OP_FIND,  10'd0,    10'd0,    1'b1, 10'd0,    1'b0},
        '{OP_FIND,  10'd1023, 10'd1023, 1'b1, 10'd1023, 1'b0},
        '{OP_UNION, 10'd0,    10'd1023, 1'b1, 10'd0,    1'b0},
        '{OP_UNION, 10'd1023, 10'd0,    1'b1, 10'd0,    1'b1},
        '{OP_FIND,  10'd1023, 10'd682,  1'b1, 10'd0,    1'b0},
        '{OP_UNION, 10'd5,    10'd5,    1'b1, 10'd5,    1'b1},
        '{OP_UNION, 10'd1,    10'd2,    1'b1, 10'd1,    1'b0},
        '{OP_UNION, 10'd3,    10'd1,    1'b1, 10'd1,    1'b0},
        '{OP_UNION, 10'd0,    10'd1,    1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd682,  10'd341,  1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd341,  10'd0,    1'b0, 10'd0,    1'b0},
        '{OP_FIND,  10'd3,    10'd341,  1'b0, 10'd0,    1'b0},
        '{OP_FIND,  10'd2,    10'd0,    1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1022, 10'd1021, 1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1020, 10'd1019, 1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1022, 10'd1020, 1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1018, 10'd1022, 1'b0, 10'd0,    1'b0},
        '{OP_FIND,  10'd1019, 10'd0,    1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1019, 10'd3,    1'b0, 10'd0,    1'b0},
        '{OP_FIND,  10'd1021, 10'd0,    1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd512,  10'd511,  1'b0, 10'd0,    1'b0},
        '{OP_FIND,  10'd511,  10'd1023, 1'b0, 10'd0,    1'b0},
        '{OP_UNION, 10'd1023, 10'd1023, 1'b0, 10'd0,    1'b0}
    };

    disjoint_set_union_find #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // first_element, second_element
        .s_tuser  (s_tuser),   // operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // root_index, already_joined
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [ELEM_W-1:0] clamp_element(input logic [ELEM_W-1:0] idx);
        if (int'(idx) >= ELEMENT_COUNT) begin
            return ELEM_W'(ELEMENT_COUNT - 1);
        end
        return idx;
    endfunction

    // root of node, then every node on the path points straight at it
    function automatic logic [ELEM_W-1:0] find_and_compress(input logic [ELEM_W-1:0] node);
        logic [ELEM_W-1:0] root;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] nxt;
        int                steps;
        root  = node;
        steps = 0;
        while (forest_parent[root] != root && steps < ELEMENT_COUNT) begin
            root = forest_parent[root];
            steps++;
        end
        cur   = node;
        steps = 0;
        while (cur != root && steps < ELEMENT_COUNT) begin
            nxt                = forest_parent[cur];
            forest_parent[cur] = root;
            cur                = nxt;
            steps++;
        end
        return root;
    endfunction

    function automatic result_t resolve_request(input logic op,
                                                input logic [ELEM_W-1:0] first,
                                                input logic [ELEM_W-1:0] second);
        result_t           res;
        logic [ELEM_W-1:0] root_a;
        logic [ELEM_W-1:0] root_b;
        res.joined = 1'b0;
        root_a     = find_and_compress(clamp_element(first));
        res.root   = root_a;
        if (op == OP_UNION) begin
            root_b = find_and_compress(clamp_element(second));
            if (root_a == root_b) begin
                res.joined = 1'b1;
            end else if (forest_rank[root_a] > forest_rank[root_b]) begin
                forest_parent[root_b] = root_a;
            end else if (forest_rank[root_a] < forest_rank[root_b]) begin
                forest_parent[root_a] = root_b;
                res.root              = root_b;
            end else begin
                forest_parent[root_b] = root_a;
                if (forest_rank[root_a] < RANK_MAX) begin
                    forest_rank[root_a] = forest_rank[root_a] + 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic offer_request(input logic op, input logic [ELEM_W-1:0] first,
                                 input logic [ELEM_W-1:0] second, input logic known,
                                 input logic [ELEM_W-1:0] known_root, input logic known_joined);
        result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - 2 * ELEM_W){1'b0}}, second, first};
        do @(posedge aclk); while (!s_tready);
        res = resolve_request(op, first, second);
        if (known) begin
            res.root   = known_root;
            res.joined = known_joined;
        end
        pending_results = {pending_results, res};
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    function automatic logic [ELEM_W-1:0] pick_element(input bit narrow);
        if (narrow) begin
            return ELEM_W'($urandom_range(0, 63));
        end
        return ELEM_W'($urandom_range(0, ELEMENT_COUNT - 1));
    endfunction

    // receiver: random holds, plus one long hold when asked
    initial begin
        m_tready   <= 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing pending, root", int'(m_tdata[ELEM_W-1:0]), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ELEM_W-1:0] != want.root) begin
                    report_mismatch("root_index", int'(m_tdata[ELEM_W-1:0]), int'(want.root));
                end
                if (m_tdata[ELEM_W] != want.joined) begin
                    report_mismatch("already_joined", int'(m_tdata[ELEM_W]), int'(want.joined));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** disjoint_set_union_find: FAILED **");
            $finish;
        end
    end

    initial begin
        bit narrow;
        logic op;
        for (int i = 0; i < ELEMENT_COUNT; i++) begin
            forest_parent[i] = ELEM_W'(i);
            forest_rank[i]   = '0;
        end
        hold_asked   = 1'b0;
        idle_on      = 1'b1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_FIND;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            offer_request(stim_table[i].op, stim_table[i].first, stim_table[i].second,
                          stim_table[i].known, stim_table[i].root, stim_table[i].joined);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            idle_on = (i < 300) || (i >= 550 && i < 950);
            if (i == 100) begin
                hold_asked = 1'b1;
            end
            narrow = ($urandom_range(0, 99) < 70);
            op     = ($urandom_range(0, 99) < 55) ? OP_UNION : OP_FIND;
            offer_request(op, pick_element(narrow), pick_element(narrow), 1'b0, '0, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** disjoint_set_union_find: PASSED **");
        end else begin
            $display("** disjoint_set_union_find: FAILED **");
        end
        $finish;
    end

endmodule

FILE: disjoint_set_union_find.f
+incdir+rtl
rtl/dsu_pkg.sv
rtl/dsu_ram.sv
rtl/disjoint_set_union_find.sv
rtl/dsu_checker.sv
sim/disjoint_set_union_find_tb.sv
